### hw/rtl/cmf_pkg.sv
package cmf_pkg;

  typedef logic [2:0] face_t;

  localparam face_t FACE_PX = 3'd0;
  localparam face_t FACE_NX = 3'd1;
  localparam face_t FACE_PY = 3'd2;
  localparam face_t FACE_NY = 3'd3;
  localparam face_t FACE_PZ = 3'd4;
  localparam face_t FACE_NZ = 3'd5;

  localparam int CFG_WIDTH_BITS = 13;
  localparam int FACE_WIDTH_RESET = 256;

  typedef struct packed {
    face_t face;
    logic  zero;
  } side_t;

  localparam int SIDE_BITS = $bits(side_t);

endpackage

### hw/rtl/cmf_fifo.sv
module cmf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hw/rtl/cmf_front.sv
module cmf_front #(
  parameter int CB = 16,
  parameter int MW = 12
) (
  input  logic signed [CB-1:0]             dir_x,
  input  logic signed [CB-1:0]             dir_y,
  input  logic signed [CB-1:0]             dir_z,
  input  logic [cmf_pkg::CFG_WIDTH_BITS-1:0] face_width,
  output cmf_pkg::side_t                   side,
  output logic [CB:0]                      sum_s,
  output logic [CB:0]                      sum_t,
  output logic [CB-1:0]                    ma,
  output logic [MW:0]                      width_eff
);
  import cmf_pkg::*;

  localparam longint WMAX = 64'd1 << MW;

  logic [CB-1:0]   ax, ay, az;
  logic signed [CB:0] xe, ye, ze, sc, tc, mae;

  assign xe = (CB+1)'(dir_x);
  assign ye = (CB+1)'(dir_y);
  assign ze = (CB+1)'(dir_z);
  assign ax = dir_x[CB-1] ? CB'(-xe) : CB'(xe);
  assign ay = dir_y[CB-1] ? CB'(-ye) : CB'(ye);
  assign az = dir_z[CB-1] ? CB'(-ze) : CB'(ze);

  always_comb begin
    side.zero = (ax == '0) && (ay == '0) && (az == '0);
    if (ax >= ay && ax >= az) begin
      ma = ax;
      tc = -ye;
      if (!dir_x[CB-1] && ax != '0) begin
        side.face = FACE_PX;
        sc = -ze;
      end else begin
        side.face = side.zero ? FACE_PX : FACE_NX;
        sc = ze;
      end
    end else if (ay >= az) begin
      ma = ay;
      sc = xe;
      if (!dir_y[CB-1]) begin
        side.face = FACE_PY;
        tc = ze;
      end else begin
        side.face = FACE_NY;
        tc = -ze;
      end
    end else begin
      ma = az;
      tc = -ye;
      if (!dir_z[CB-1]) begin
        side.face = FACE_PZ;
        sc = xe;
      end else begin
        side.face = FACE_NZ;
        sc = -xe;
      end
    end
  end

  assign mae   = $signed({1'b0, ma});
  assign sum_s = (CB+1)'(sc + mae);
  assign sum_t = (CB+1)'(tc + mae);

  always_comb begin
    if (face_width == '0) begin
      width_eff = (MW+1)'(1);
    end else if (64'(face_width) > WMAX) begin
      width_eff = (MW+1)'(WMAX);
    end else begin
      width_eff = (MW+1)'(face_width);
    end
  end

endmodule

### hw/rtl/cmf_back.sv
module cmf_back #(
  parameter int CB = 16,
  parameter int MW = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_take,
  input  cmf_pkg::side_t       in_side,
  input  logic [CB:0]          in_sum_s,
  input  logic [CB:0]          in_sum_t,
  input  logic [CB-1:0]        in_ma,
  input  logic [MW:0]          in_width,
  output logic                 res_valid,
  input  logic                 res_full,
  output cmf_pkg::side_t       res_side,
  output logic [MW-1:0]        res_texel_x,
  output logic [MW-1:0]        res_texel_y
);
  import cmf_pkg::*;

  localparam int QB = MW + 1;
  localparam int NW = CB + MW + 2;

  logic          v_r    [QB+1];
  side_t         side_r [QB+1];
  logic [NW-1:0] rs_r   [QB+1];
  logic [NW-1:0] rt_r   [QB+1];
  logic [QB-1:0] qs_r   [QB+1];
  logic [QB-1:0] qt_r   [QB+1];
  logic [CB:0]   d_r    [QB+1];
  logic [MW:0]   w_r    [QB+1];
  logic          en;
  logic [MW:0]   wm1;
  logic [QB-1:0] cs, ct;

  assign en      = !(v_r[QB] && res_full);
  assign in_take = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QB; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= QB; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      rs_r[0]   <= NW'(in_sum_s * in_width);
      rt_r[0]   <= NW'(in_sum_t * in_width);
      qs_r[0]   <= '0;
      qt_r[0]   <= '0;
      d_r[0]    <= {in_ma, 1'b0};
      w_r[0]    <= in_width;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic [NW-1:0] dsh;
    logic          ges, get;

    assign dsh = NW'(d_r[k]) << B;
    assign ges = rs_r[k] >= dsh;
    assign get = rt_r[k] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= side_r[k];
        rs_r[k+1]   <= ges ? rs_r[k] - dsh : rs_r[k];
        rt_r[k+1]   <= get ? rt_r[k] - dsh : rt_r[k];
        qs_r[k+1]   <= {qs_r[k][QB-2:0], ges};
        qt_r[k+1]   <= {qt_r[k][QB-2:0], get};
        d_r[k+1]    <= d_r[k];
        w_r[k+1]    <= w_r[k];
      end
    end
  end

  assign wm1 = w_r[QB] - 1'b1;
  assign cs  = (qs_r[QB] > wm1) ? wm1 : qs_r[QB];
  assign ct  = (qt_r[QB] > wm1) ? wm1 : qt_r[QB];

  assign res_valid   = v_r[QB];
  assign res_side    = side_r[QB];
  assign res_texel_x = side_r[QB].zero ? '0 : cs[MW-1:0];
  assign res_texel_y = side_r[QB].zero ? '0 : ct[MW-1:0];

endmodule

### hw/rtl/cube_map_face_texel_address_core.sv
// Path from accepted request to empty going low: front queue, product stage,
// one quotient bit per divider stage, result queue.
// Throughput: one request per cycle; the divider pipeline stalls only while a finished
// result waits and the result queue is full.
// Reset: synchronous active-low rst_n empties both queues and the pipeline and
// sets face_width to 256.
module cube_map_face_texel_address_core #(
  parameter int COMPONENT_BITS      = 16,
  parameter int MAX_FACE_WIDTH_LOG2 = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write_en,
  input  logic [cmf_pkg::CFG_WIDTH_BITS-1:0]  cfg_face_width,
  input  logic                                push,
  output logic                                full,
  input  logic signed [COMPONENT_BITS-1:0]    in_dir_x,
  input  logic signed [COMPONENT_BITS-1:0]    in_dir_y,
  input  logic signed [COMPONENT_BITS-1:0]    in_dir_z,
  output logic                                empty,
  input  logic                                pop,
  output cmf_pkg::face_t                      out_face,
  output logic [MAX_FACE_WIDTH_LOG2-1:0]      out_texel_x,
  output logic [MAX_FACE_WIDTH_LOG2-1:0]      out_texel_y,
  output logic                                out_zero_vector
);
  import cmf_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int MW = MAX_FACE_WIDTH_LOG2;
  localparam int MID_W = SIDE_BITS + 2 * (CB + 1) + CB + MW + 1;
  localparam int OUT_W = SIDE_BITS + 2 * MW;

  logic [CFG_WIDTH_BITS-1:0] face_width_r;

  side_t          f_side, b_side, r_side;
  logic [CB:0]    f_sum_s, f_sum_t, b_sum_s, b_sum_t;
  logic [CB-1:0]  f_ma, b_ma;
  logic [MW:0]    f_w, b_w;
  logic [MID_W-1:0] mid_wdata, mid_rdata;
  logic           mid_empty, mid_pop, b_take;
  logic           r_valid, r_full;
  logic [MW-1:0]  r_tx, r_ty;
  logic [OUT_W-1:0] out_rdata;
  side_t          o_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_width_r <= CFG_WIDTH_BITS'(FACE_WIDTH_RESET);
    end else if (cfg_write_en) begin
      face_width_r <= cfg_face_width;
    end
  end

  cmf_front #(.CB(CB), .MW(MW)) u_front (
    .dir_x      (in_dir_x),
    .dir_y      (in_dir_y),
    .dir_z      (in_dir_z),
    .face_width (face_width_r),
    .side       (f_side),
    .sum_s      (f_sum_s),
    .sum_t      (f_sum_t),
    .ma         (f_ma),
    .width_eff  (f_w)
  );

  assign mid_wdata = {f_side, f_sum_s, f_sum_t, f_ma, f_w};

  cmf_fifo #(.WIDTH(MID_W), .DEPTH(2)) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (mid_wdata),
    .full    (full),
    .rd_en   (mid_pop),
    .rd_data (mid_rdata),
    .empty   (mid_empty)
  );

  assign {b_side, b_sum_s, b_sum_t, b_ma, b_w} = mid_rdata;
  assign mid_pop = b_take && !mid_empty;

  cmf_back #(.CB(CB), .MW(MW)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (!mid_empty),
    .in_take     (b_take),
    .in_side     (b_side),
    .in_sum_s    (b_sum_s),
    .in_sum_t    (b_sum_t),
    .in_ma       (b_ma),
    .in_width    (b_w),
    .res_valid   (r_valid),
    .res_full    (r_full),
    .res_side    (r_side),
    .res_texel_x (r_tx),
    .res_texel_y (r_ty)
  );

  cmf_fifo #(.WIDTH(OUT_W), .DEPTH(2)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (r_valid),
    .wr_data ({r_side, r_tx, r_ty}),
    .full    (r_full),
    .rd_en   (pop),
    .rd_data (out_rdata),
    .empty   (empty)
  );

  assign {o_side, out_texel_x, out_texel_y} = out_rdata;
  assign out_face        = o_side.face;
  assign out_zero_vector = o_side.zero;

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_zero_vector |-> out_face == FACE_PX && out_texel_x == '0
      && out_texel_y == '0)
    else $error("zero vector result not +X at texel 0,0");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_face == FACE_PX || out_face == FACE_NX || out_face == FACE_PY
      || out_face == FACE_NY || out_face == FACE_PZ || out_face == FACE_NZ)
    else $error("face code out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> empty && !full)
    else $error("queues not cleared by reset");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    r_valid && r_full |=> r_valid)
    else $error("result lost while result queue full");

endmodule
